// ----- rtl/tsfdo_pkg.sv -----
// Shared types and constants for the touch sample ring with drop-oldest overflow.
// Holds the stored record layout, item kind codes and default ring depth.
// No dependencies.
package tsfdo_pkg;

    // default number of ring entries (ring holds one less record)
    localparam int DEPTH_DEF = 64;

    // coordinate and count widths
    localparam int COORD_W = 10;
    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // item kinds
    typedef enum logic [1:0] {
        KIND_CONTACT = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_POP     = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // one stored record, 62 bits
    typedef struct packed {
        logic [COORD_W-1:0] pressure;
        logic [COORD_W-1:0] y_minus;
        logic [COORD_W-1:0] y_plus;
        logic [COORD_W-1:0] x_minus;
        logic [COORD_W-1:0] x_plus;
        logic               sample;
        logic               pen;
        logic               hard;
        logic               soft_mark;
        logic [COUNT_W-1:0] count;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

// ----- rtl/tsfdo_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Parameters set word width and depth. No dependencies.
module tsfdo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/touch_sample_fifo_drop_oldest_unit.sv -----
// Top level of the touch sample ring with drop-oldest overflow.
// Depends on tsfdo_pkg and tsfdo_ram.
//
// An item is taken when start is high and busy is low. A push of a contact-change
// or sample record keeps busy through ST_PUSH_WR, and also through ST_OV_RD and
// ST_OV_WR when the push overflows the ring, since the oldest and the next-oldest
// record are then read from the single-read-port record memory one after another
// and the next-oldest is written back with the lost marks. A pop keeps busy
// through ST_POP_RD and ST_POP_OUT (the registered memory read), or only ST_POP_RD
// when the ring is empty, and its result is shown for one cycle on the result
// ports with done high, in the first cycle in which busy is low again; the
// receiver cannot stall and must take it then. An empty pop reports empty_res
// with all other fields zero. Kind 3 is taken and ignored. The ring holds DEPTH-1
// records; no clearing pass is needed after reset.
module touch_sample_fifo_drop_oldest_unit
    import tsfdo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   kind,
    input  logic         pen_down,
    input  logic         hard_lost,
    input  logic [9:0]   xp_sample,
    input  logic [9:0]   xm_sample,
    input  logic [9:0]   yp_sample,
    input  logic [9:0]   ym_sample,
    input  logic [9:0]   z_sample,
    output logic         done,
    output logic         empty_res,
    output logic         xyz_valid,
    output logic         pen_contact,
    output logic         soft_lost,
    output logic         hard_lost_out,
    output logic [7:0]   lost_count,
    output logic [9:0]   x_plus,
    output logic [9:0]   x_minus,
    output logic [9:0]   y_plus,
    output logic [9:0]   y_minus,
    output logic [9:0]   pressure
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_PUSH_WR = 6'b000010,
        ST_OV_RD   = 6'b000100,
        ST_OV_WR   = 6'b001000,
        ST_POP_RD  = 6'b010000,
        ST_POP_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] wi_reg, wi_next;
    logic [AW-1:0] ri_reg, ri_next;
    logic          done_reg, done_next;

    // latched item payload
    kind_t              kind_reg;
    logic               pen_reg;
    logic               hard_reg;
    logic [COORD_W-1:0] xp_reg, xm_reg, yp_reg, ym_reg, z_reg;

    // dropped record marks carried to the write-back
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               drop_hard_reg, drop_hard_next;

    // result register
    rec_t out_rec_reg, out_rec_next;
    logic out_empty_reg, out_empty_next;

    // memory ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    rec_t          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    rec_t          rd_rec;
    rec_t          new_rec;

    logic accept;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
        ring_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign rd_rec = rec_t'(ram_rdata);

    // record memory
    tsfdo_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // record built from the latched push item
    always_comb
    begin
        new_rec        = '0;
        new_rec.hard   = hard_reg;
        if (kind_reg == KIND_SAMPLE)
        begin
            new_rec.sample   = 1'b1;
            new_rec.pen      = 1'b1;
            new_rec.x_plus   = xp_reg;
            new_rec.x_minus  = xm_reg;
            new_rec.y_plus   = yp_reg;
            new_rec.y_minus  = ym_reg;
            new_rec.pressure = z_reg;
        end
        else
        begin
            new_rec.pen = pen_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        wi_next        = wi_reg;
        ri_next        = ri_reg;
        done_next      = 1'b0;
        cnt_next       = cnt_reg;
        drop_hard_next = drop_hard_reg;
        out_rec_next   = out_rec_reg;
        out_empty_next = out_empty_reg;
        ram_we         = 1'b0;
        ram_waddr      = wi_reg;
        ram_wdata      = new_rec;
        ram_raddr      = ri_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        KIND_CONTACT, KIND_SAMPLE: state_next = ST_PUSH_WR;
                        KIND_POP:                  state_next = ST_POP_RD;
                        default:                   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH_WR:
            begin
                // store the record, fetch the oldest in case of overflow
                ram_we    = 1'b1;
                ram_waddr = wi_reg;
                ram_wdata = new_rec;
                ram_raddr = ri_reg;
                wi_next   = ring_inc(wi_reg);
                if (ring_inc(wi_reg) == ri_reg)
                begin
                    state_next = ST_OV_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OV_RD:
            begin
                // drop the oldest record, fetch the new oldest
                cnt_next = rd_rec.count;
                if (rd_rec.sample && (rd_rec.count != COUNT_MAX))
                begin
                    cnt_next = rd_rec.count + 1'b1;
                end
                drop_hard_next = rd_rec.hard;
                ri_next        = ring_inc(ri_reg);
                ram_raddr      = ring_inc(ri_reg);
                state_next     = ST_OV_WR;
            end
            ST_OV_WR:
            begin
                // mark the new oldest record and write it back
                ram_we              = 1'b1;
                ram_waddr           = ri_reg;
                ram_wdata           = rd_rec;
                ram_wdata.count     = cnt_reg;
                ram_wdata.soft_mark = 1'b1;
                ram_wdata.hard      = rd_rec.hard | drop_hard_reg;
                state_next          = ST_IDLE;
            end
            ST_POP_RD:
            begin
                ram_raddr = ri_reg;
                if (wi_reg == ri_reg)
                begin
                    out_rec_next   = '0;
                    out_empty_next = 1'b1;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ri_next    = ring_inc(ri_reg);
                    state_next = ST_POP_OUT;
                end
            end
            ST_POP_OUT:
            begin
                out_rec_next   = rd_rec;
                out_empty_next = 1'b0;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wi_reg    <= '0;
            ri_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wi_reg    <= wi_next;
            ri_reg    <= ri_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_t'(kind);
            pen_reg  <= pen_down;
            hard_reg <= hard_lost;
            xp_reg   <= xp_sample;
            xm_reg   <= xm_sample;
            yp_reg   <= yp_sample;
            ym_reg   <= ym_sample;
            z_reg    <= z_sample;
        end
        cnt_reg       <= cnt_next;
        drop_hard_reg <= drop_hard_next;
        out_rec_reg   <= out_rec_next;
        out_empty_reg <= out_empty_next;
    end

    // result ports
    assign done          = done_reg;
    assign empty_res     = out_empty_reg;
    assign xyz_valid     = out_rec_reg.sample;
    assign pen_contact   = out_rec_reg.pen;
    assign soft_lost     = out_rec_reg.soft_mark;
    assign hard_lost_out = out_rec_reg.hard;
    assign lost_count    = out_rec_reg.count;
    assign x_plus        = out_rec_reg.x_plus;
    assign x_minus       = out_rec_reg.x_minus;
    assign y_plus        = out_rec_reg.y_plus;
    assign y_minus       = out_rec_reg.y_minus;
    assign pressure      = out_rec_reg.pressure;

endmodule

// ----- bench/touch_sample_fifo_drop_oldest_unit_tb.sv -----
// Self-checking testbench for the touch sample ring with drop-oldest overflow.
// Tracks the record ring in a scoreboard class and checks every pop result.
// Depends on tsfdo_pkg and touch_sample_fifo_drop_oldest_unit.
module touch_sample_fifo_drop_oldest_unit_tb
    import tsfdo_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1800;

    // one pop result as seen on the result ports
    typedef struct packed {
        logic               empty;
        logic               xyz;
        logic               pen;
        logic               soft_mark;
        logic               hard;
        logic [COUNT_W-1:0] count;
        logic [COORD_W-1:0] xp;
        logic [COORD_W-1:0] xm;
        logic [COORD_W-1:0] yp;
        logic [COORD_W-1:0] ym;
        logic [COORD_W-1:0] z;
    } pop_result_t;

    // ring tracker: own copy of the record ring and the pops still owed
    class record_ring_tracker;
        rec_t        slots [DEPTH_DEF];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        pop_result_t owed_pops [$];
        int          mismatch_count;

        function new();
            wr_ptr = 0;
            rd_ptr = 0;
            mismatch_count = 0;
        endfunction

        // apply one accepted item to the ring
        function void note_item(kind_t k, logic pen, logic hard, logic [COORD_W-1:0] xp,
                                logic [COORD_W-1:0] xm, logic [COORD_W-1:0] yp,
                                logic [COORD_W-1:0] ym, logic [COORD_W-1:0] z);
            rec_t        fresh;
            rec_t        dropped;
            pop_result_t res;
            logic [COUNT_W-1:0] cnt;
            fresh = '0;
            res = '0;
            case (k)
                KIND_CONTACT, KIND_SAMPLE:
                begin
                    fresh.hard = hard;
                    if (k == KIND_SAMPLE)
                    begin
                        fresh.sample = 1'b1;
                        fresh.pen = 1'b1;
                        fresh.x_plus = xp;
                        fresh.x_minus = xm;
                        fresh.y_plus = yp;
                        fresh.y_minus = ym;
                        fresh.pressure = z;
                    end
                    else
                    begin
                        fresh.pen = pen;
                    end
                    slots[wr_ptr] = fresh;
                    wr_ptr = (wr_ptr + 1) % DEPTH_DEF;
                    // overflow: drop the oldest, mark the new oldest
                    if (wr_ptr == rd_ptr)
                    begin
                        dropped = slots[rd_ptr];
                        cnt = dropped.count;
                        if (dropped.sample && cnt != COUNT_MAX)
                            cnt = cnt + 1'b1;
                        rd_ptr = (rd_ptr + 1) % DEPTH_DEF;
                        slots[rd_ptr].count = cnt;
                        slots[rd_ptr].soft_mark = 1'b1;
                        slots[rd_ptr].hard = slots[rd_ptr].hard | dropped.hard;
                    end
                end
                KIND_POP:
                begin
                    if (wr_ptr == rd_ptr)
                    begin
                        res.empty = 1'b1;
                    end
                    else
                    begin
                        fresh = slots[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % DEPTH_DEF;
                        res.xyz = fresh.sample;
                        res.pen = fresh.pen;
                        res.soft_mark = fresh.soft_mark;
                        res.hard = fresh.hard;
                        res.count = fresh.count;
                        res.xp = fresh.x_plus;
                        res.xm = fresh.x_minus;
                        res.yp = fresh.y_plus;
                        res.ym = fresh.y_minus;
                        res.z = fresh.pressure;
                    end
                    owed_pops.push_back(res);
                end
                default:
                begin
                    // unused kind: no effect
                end
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        // check one result against the oldest owed pop
        function void check_pop(pop_result_t got);
            pop_result_t want;
            if (owed_pops.size() == 0)
            begin
                $error("result arrived with no pop outstanding");
                mismatch_count++;
                return;
            end
            want = owed_pops.pop_front();
            compare_field("empty_res", 32'(want.empty), 32'(got.empty));
            compare_field("xyz_valid", 32'(want.xyz), 32'(got.xyz));
            compare_field("pen_contact", 32'(want.pen), 32'(got.pen));
            compare_field("soft_lost", 32'(want.soft_mark), 32'(got.soft_mark));
            compare_field("hard_lost_out", 32'(want.hard), 32'(got.hard));
            compare_field("lost_count", 32'(want.count), 32'(got.count));
            compare_field("x_plus", 32'(want.xp), 32'(got.xp));
            compare_field("x_minus", 32'(want.xm), 32'(got.xm));
            compare_field("y_plus", 32'(want.yp), 32'(got.yp));
            compare_field("y_minus", 32'(want.ym), 32'(got.ym));
            compare_field("pressure", 32'(want.z), 32'(got.z));
        endfunction

        function int outstanding();
            return owed_pops.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic               pen_down;
    logic               hard_lost;
    logic [COORD_W-1:0] xp_sample;
    logic [COORD_W-1:0] xm_sample;
    logic [COORD_W-1:0] yp_sample;
    logic [COORD_W-1:0] ym_sample;
    logic [COORD_W-1:0] z_sample;
    logic               done;
    logic               empty_res;
    logic               xyz_valid;
    logic               pen_contact;
    logic               soft_lost;
    logic               hard_lost_out;
    logic [COUNT_W-1:0] lost_count;
    logic [COORD_W-1:0] x_plus;
    logic [COORD_W-1:0] x_minus;
    logic [COORD_W-1:0] y_plus;
    logic [COORD_W-1:0] y_minus;
    logic [COORD_W-1:0] pressure;

    record_ring_tracker ring_track = new();
    int issued = 0;

    touch_sample_fifo_drop_oldest_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .pen_down      (pen_down),
        .hard_lost     (hard_lost),
        .xp_sample     (xp_sample),
        .xm_sample     (xm_sample),
        .yp_sample     (yp_sample),
        .ym_sample     (ym_sample),
        .z_sample      (z_sample),
        .done          (done),
        .empty_res     (empty_res),
        .xyz_valid     (xyz_valid),
        .pen_contact   (pen_contact),
        .soft_lost     (soft_lost),
        .hard_lost_out (hard_lost_out),
        .lost_count    (lost_count),
        .x_plus        (x_plus),
        .x_minus       (x_minus),
        .y_plus        (y_plus),
        .y_minus       (y_minus),
        .pressure      (pressure)
    );

    // clock
    always #5 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        pop_result_t got;
        if (rst_n && done)
        begin
            got.empty = empty_res;
            got.xyz = xyz_valid;
            got.pen = pen_contact;
            got.soft_mark = soft_lost;
            got.hard = hard_lost_out;
            got.count = lost_count;
            got.xp = x_plus;
            got.xm = x_minus;
            got.yp = y_plus;
            got.ym = y_minus;
            got.z = pressure;
            ring_track.check_pop(got);
        end
    end

    // drive one item from a falling edge, return at a falling edge after acceptance
    task automatic send_item(kind_t k, logic pen, logic hard, logic [COORD_W-1:0] xp,
                             logic [COORD_W-1:0] xm, logic [COORD_W-1:0] yp,
                             logic [COORD_W-1:0] ym, logic [COORD_W-1:0] z);
        bit quiet;
        start <= 1'b1;
        kind <= k;
        pen_down <= pen;
        hard_lost <= hard;
        xp_sample <= xp;
        xm_sample <= xm;
        yp_sample <= yp;
        ym_sample <= ym;
        z_sample <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ring_track.note_item(k, pen, hard, xp, xm, yp, ym, z);
        @(negedge clk);
        // random sender gaps, none inside the quiet stretch
        quiet = (issued >= 700 && issued < 1000);
        if (!quiet && $urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(negedge clk);
        end
    endtask

    // stop sending until every owed pop result has come back
    task automatic drain_wait();
        start <= 1'b0;
        do
            @(negedge clk);
        while (ring_track.outstanding() != 0);
    endtask

    // one random item; push share and sample share in percent
    task automatic random_item(int push_pct, int sample_pct);
        kind_t k;
        logic  hard;
        if ($urandom_range(0, 99) < 3)
            k = KIND_NONE;
        else if ($urandom_range(0, 99) < push_pct)
            k = ($urandom_range(0, 99) < sample_pct) ? KIND_SAMPLE : KIND_CONTACT;
        else
            k = KIND_POP;
        hard = ($urandom_range(0, 7) == 0);
        send_item(k, 1'($urandom_range(0, 1)), hard, 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        if (k != KIND_NONE)
            issued++;
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int phase_n;
        int push_pct;
        int sample_pct;
        int len;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_NONE;
        pen_down = 1'b0;
        hard_lost = 1'b0;
        xp_sample = '0;
        xm_sample = '0;
        yp_sample = '0;
        ym_sample = '0;
        z_sample = '0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty pop, both record kinds, field extremes, unused kind
        send_item(KIND_POP, 1'b1, 1'b1, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
        send_item(KIND_CONTACT, 1'b1, 1'b0, 10'h3ff, 10'h000, 10'h3ff, 10'h000, 10'h3ff);
        send_item(KIND_CONTACT, 1'b0, 1'b1, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000);
        send_item(KIND_SAMPLE, 1'b0, 1'b0, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
        send_item(KIND_SAMPLE, 1'b1, 1'b1, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000);
        send_item(KIND_SAMPLE, 1'b0, 1'b0, 10'h2aa, 10'h155, 10'h2aa, 10'h155, 10'h2aa);
        send_item(KIND_NONE, 1'b1, 1'b1, 10'h155, 10'h2aa, 10'h155, 10'h2aa, 10'h155);
        repeat (7)
            send_item(KIND_POP, 1'b0, 1'b0, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000);
        send_item(KIND_CONTACT, 1'b1, 1'b1, 10'h155, 10'h2aa, 10'h155, 10'h2aa, 10'h155);
        send_item(KIND_NONE, 1'b0, 1'b0, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000);
        send_item(KIND_POP, 1'b0, 1'b0, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000);
        send_item(KIND_POP, 1'b0, 1'b0, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000);
        drain_wait();

        // random phases; a long sample flood then a drain drives the count to saturation
        phase_n = 0;
        while (issued < ITEM_TARGET)
        begin
            sample_pct = 60;
            if (phase_n == 2)
            begin
                push_pct = 100;
                sample_pct = 90;
                len = 400;
            end
            else if (phase_n == 3)
            begin
                push_pct = 0;
                len = 70;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: push_pct = 50;
                    1: push_pct = 85;
                    2: push_pct = 20;
                    default: push_pct = 65;
                endcase
                len = $urandom_range(40, 160);
            end
            repeat (len)
                if (issued < ITEM_TARGET)
                    random_item(push_pct, sample_pct);
            if ($urandom_range(0, 3) == 0)
                drain_wait();
            phase_n++;
        end

        // wait for the last results, then watch for stray strobes
        drain_wait();
        repeat (8)
            @(posedge clk);
        if (ring_track.mismatch_count == 0 && ring_track.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
